// ===== design/trade_anomaly_detector_core_macros.svh =====
`ifndef TRADE_ANOMALY_DETECTOR_CORE_MACROS_SVH
`define TRADE_ANOMALY_DETECTOR_CORE_MACROS_SVH

// A check whose consequent must hold in the same cycle as its trigger.
`define TAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A check whose consequent must hold in the cycle after its trigger.
`define TAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tad_pkg.sv =====
`timescale 1ns / 1ps

package tad_pkg;

    // Log2 values are unsigned, six integer bits and 34 fraction bits.
    localparam int LOG_FRAC = 34;
    localparam int LOG_INT  = 6;
    localparam int LOG_W    = LOG_INT + LOG_FRAC;
    localparam int MANT_W   = 32;
    localparam int MAG_W    = LOG_FRAC + 2;

    localparam logic [LOG_W-1:0] LOG_CAP = LOG_W'(64'd3 << LOG_FRAC);
    localparam logic [27:0]      LN2_Q28 = 28'd186065280;

    localparam int VAR_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Reciprocal constants for n*9/10 and m*19/20 (exact for the window sizes in use).
    localparam logic [31:0] K_VOL_MUL  = 32'd58986;
    localparam logic [31:0] K_STEP_MUL = 32'd62263;
    localparam int          K_SHIFT    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MULT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_MULT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_FLOOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRADES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_log_stat;

endpackage

// ===== design/tad_log2.sv =====
`timescale 1ns / 1ps

module tad_log2 #(
    parameter int NW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NW-1:0]             i_value,
    output tad_pkg::t_log_stat        o_stat,
    output logic [tad_pkg::LOG_W-1:0] o_log
);
    import tad_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQR  = 2'd2;

    logic [1:0]          r_state;
    logic [NW-1:0]       r_norm;
    logic [LOG_INT-1:0]  r_exp;
    logic [MANT_W-1:0]   r_mant;
    logic [LOG_FRAC-1:0] r_frac;
    logic [5:0]          r_iter;
    logic                r_done;
    logic [2*MANT_W-1:0] w_sq;
    logic [MANT_W:0]     w_sh;

    // The square of a mantissa in [1,2) lies in [1,4), so it keeps one extra integer bit.
    assign w_sq = r_mant * r_mant;
    assign w_sh = w_sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        // A zero counts as one inside the logarithm.
                        r_norm  <= (i_value == '0) ? NW'(1) : i_value;
                        r_exp   <= LOG_INT'(NW - 1);
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (r_norm[NW-1]) begin
                        r_mant  <= r_norm[NW-1 -: MANT_W];
                        r_iter  <= 6'(LOG_FRAC);
                        r_state <= L_SQR;
                    end else begin
                        r_norm <= r_norm << 1;
                        r_exp  <= r_exp - 1'b1;
                    end
                end
                L_SQR: begin
                    if (w_sh[MANT_W]) begin
                        r_mant <= w_sh[MANT_W:1];
                        r_frac <= {r_frac[LOG_FRAC-2:0], 1'b1};
                    end else begin
                        r_mant <= w_sh[MANT_W-1:0];
                        r_frac <= {r_frac[LOG_FRAC-2:0], 1'b0};
                    end
                    r_iter <= r_iter - 1'b1;
                    if (r_iter == 6'd1) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != L_IDLE);
    assign o_stat.done = r_done;
    assign o_log       = {r_exp, r_frac};

endmodule

// ===== design/trade_anomaly_detector_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_price, i_volume
// result    o_out_valid / i_out_ready    o_price_alert, o_size_alert,
//                                        o_volatility_alert, o_variance
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item is processed at a time. After acceptance the logarithm normalises the price
// and then squares the mantissa once per fraction bit; the EWMA update (RET, SQ, EWMA,
// SAT; skipped for the first trade), setup, the window sweeps, comparison and result
// follow. The sweeps make VALUE_BITS passes once the window holds min_trades items,
// otherwise one, each reading the n entries of the window fill. A new item is taken
// only after the last result is loaded. A result not yet collected holds the sequencer
// in its last state; reset is synchronous and active low, the window memories need no
// clearing pass, and configuration writes are always ready and registered directly.
module trade_anomaly_detector_core #(
    parameter int WINDOW     = 50,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [VALUE_BITS-1:0]          i_price,
    input  logic [VALUE_BITS-1:0]          i_volume,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_price_alert,
    output logic                           o_size_alert,
    output logic                           o_volatility_alert,
    output logic [tad_pkg::VAR_W-1:0]      o_variance,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tad_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tad_pkg::*;

    localparam int VB   = VALUE_BITS;
    localparam int NW   = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int AW   = $clog2(WINDOW);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SW   = VB + CW;
    localparam int CMPW = SW + 16;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOG     = 4'd1;
    localparam logic [3:0] S_RET     = 4'd2;
    localparam logic [3:0] S_SQ      = 4'd3;
    localparam logic [3:0] S_EWMA    = 4'd4;
    localparam logic [3:0] S_SAT     = 4'd5;
    localparam logic [3:0] S_SETUP   = 4'd6;
    localparam logic [3:0] S_PASS    = 4'd7;
    localparam logic [3:0] S_RESOLVE = 4'd8;
    localparam logic [3:0] S_CMP     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // Configuration registers.
    logic [15:0]      r_decay;
    logic [15:0]      r_size_mult;
    logic [15:0]      r_dev_mult;
    logic [31:0]      r_size_floor;
    logic [31:0]      r_move_floor;
    logic [VAR_W-1:0] r_var_limit;
    logic [5:0]       r_min_trades;
    logic [VAR_W-1:0] r_init_var;

    // Persistent detector state.
    logic [3:0]       r_state;
    logic [AW-1:0]    r_wslot;
    logic [CW-1:0]    r_fill;
    logic [VB-1:0]    r_last_price;
    logic [LOG_W-1:0] r_last_log;
    logic [VAR_W-1:0] r_var;
    logic             r_started;
    logic [NW-1:0]    r_size_thr;
    logic [NW-1:0]    r_move_thr;

    // Window memories: volume and absolute price step, one entry per slot.
    logic [VB-1:0] r_vol_mem  [WINDOW];
    logic [VB-1:0] r_step_mem [WINDOW];
    logic [VB-1:0] r_rd_vol;
    logic [VB-1:0] r_rd_step;

    // Per-item working registers.
    logic [VB-1:0]    r_volume;
    logic [VB-1:0]    r_change;
    logic [MAG_W-1:0] r_mag;
    logic [30:0]      r_ret;
    logic [41:0]      r_sq;
    logic [55:0]      r_p1;
    logic [58:0]      r_p2;

    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_issue;
    logic          r_dv;
    logic          r_d_first;
    logic          r_first_pass;
    logic [VB-1:0] r_bitm;
    logic [VB-1:0] r_himask;
    logic [VB-1:0] r_pref_v;
    logic [VB-1:0] r_pref_s;
    logic [CW-1:0] r_k_v;
    logic [CW-1:0] r_k_s;
    logic [CW-1:0] r_c_v;
    logic [CW-1:0] r_c_s;
    logic [SW-1:0] r_vsum;
    logic [SW-1:0] r_ssum;

    logic [VB+CW-1:0] r_pv1;
    logic [SW+15:0]   r_pv2;
    logic [VB+CW-1:0] r_ps1;
    logic [SW+15:0]   r_ps2;

    // Result register.
    logic             r_ov;
    logic             r_pa;
    logic             r_sa;
    logic             r_va;
    logic [VAR_W-1:0] r_ovar;

    logic [3:0]       n_state;
    logic             w_in_acc;
    logic             w_load_out;
    logic [VB-1:0]    w_step;
    logic [AW-1:0]    w_oldest;
    logic [AW-1:0]    w_addr_inc;
    logic             w_enough;
    logic             w_vmatch;
    logic             w_smatch;
    logic             w_v_hi;
    logic             w_s_hi;
    logic [VB-1:0]    w_pref_v_nx;
    logic [VB-1:0]    w_pref_s_nx;
    logic [LOG_W-1:0] w_ldiff;
    logic [63:0]      w_ret_sum;
    logic [61:0]      w_sq_sum;
    logic [59:0]      w_ewma_sum;
    logic [16:0]      w_new_wt;
    logic             w_pa;
    logic             w_sa;
    logic             w_va;
    t_log_stat        w_log_stat;
    logic [LOG_W-1:0] w_log;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_step = (i_price > r_last_price) ? i_price - r_last_price
                                             : r_last_price - i_price;

    // Until the window is full it starts at slot zero; after that at the write slot.
    assign w_oldest   = (32'(r_fill) < WINDOW) ? '0 : r_wslot;
    assign w_addr_inc = (32'(r_addr) == WINDOW - 1) ? '0 : r_addr + 1'b1;
    assign w_enough   = (32'(r_fill) >= 32'(r_min_trades));

    // An entry counts for the current bit when it shares the prefix found so far and
    // has a zero in the bit under test.
    assign w_vmatch = (((r_rd_vol ^ r_pref_v) & r_himask) == '0) &&
                      ((r_rd_vol & r_bitm) == '0);
    assign w_smatch = (((r_rd_step ^ r_pref_s) & r_himask) == '0) &&
                      ((r_rd_step & r_bitm) == '0);

    assign w_v_hi      = !(r_k_v < r_c_v);
    assign w_s_hi      = !(r_k_s < r_c_s);
    assign w_pref_v_nx = w_v_hi ? (r_pref_v | r_bitm) : r_pref_v;
    assign w_pref_s_nx = w_s_hi ? (r_pref_s | r_bitm) : r_pref_s;

    // Log return and its square.
    assign w_ldiff    = (w_log > r_last_log) ? w_log - r_last_log : r_last_log - w_log;
    assign w_ret_sum  = 64'(r_mag) * 64'(LN2_Q28) + 64'h0000_0000_8000_0000;
    assign w_sq_sum   = 62'(r_ret) * 62'(r_ret) + 62'h8_0000;
    assign w_new_wt   = 17'h1_0000 - 17'(r_decay);
    assign w_ewma_sum = 60'(r_p1) + 60'(r_p2) + 60'h8000;

    // Anomaly decisions; the thresholds used here already include this item.
    assign w_pa = (32'(r_fill) >= 2) && (r_ssum != '0) &&
                  ((NW'(r_change) > r_move_thr) ||
                   (CMPW'({r_ps1, 8'h00}) > CMPW'(r_ps2)));
    assign w_sa = (NW'(r_volume) > r_size_thr) ||
                  (w_enough && (r_vsum != '0) &&
                   (CMPW'({r_pv1, 8'h00}) > CMPW'(r_pv2)));
    assign w_va = (r_var > r_var_limit);

    assign w_load_out = (r_state == S_DONE) && (!r_ov || i_out_ready);

    tad_log2 #(
        .NW (NW)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_value (NW'(i_price)),
        .o_stat  (w_log_stat),
        .o_log   (w_log)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_acc) n_state = S_LOG;
            S_LOG: begin
                if (w_log_stat.done) begin
                    n_state = r_started ? S_RET : S_SETUP;
                end
            end
            S_RET:     n_state = S_SQ;
            S_SQ:      n_state = S_EWMA;
            S_EWMA:    n_state = S_SAT;
            S_SAT:     n_state = S_SETUP;
            S_SETUP:   n_state = S_PASS;
            S_PASS: begin
                if (r_issue == r_fill && !r_dv) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if ((r_first_pass && !w_enough) || r_bitm[0]) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_CMP:     n_state = S_DONE;
            S_DONE:    if (w_load_out) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Window memories: written once per item, read one entry per cycle during sweeps.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_vol_mem[r_wslot]  <= i_volume;
            r_step_mem[r_wslot] <= w_step;
        end
        r_rd_vol  <= r_vol_mem[r_addr];
        r_rd_step <= r_step_mem[r_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay      <= 16'd60293;
            r_size_mult  <= 16'd768;
            r_dev_mult   <= 16'd640;
            r_size_floor <= 32'd10000;
            r_move_floor <= 32'd1000;
            r_var_limit  <= 40'd439804651;
            r_min_trades <= 6'd10;
            r_init_var   <= 40'd109951163;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DECAY:      r_decay      <= i_cfg_data[15:0];
                CFG_SIZE_MULT:  r_size_mult  <= i_cfg_data[15:0];
                CFG_DEV_MULT:   r_dev_mult   <= i_cfg_data[15:0];
                CFG_SIZE_FLOOR: r_size_floor <= i_cfg_data[31:0];
                CFG_MOVE_FLOOR: r_move_floor <= i_cfg_data[31:0];
                CFG_VAR_LIMIT:  r_var_limit  <= i_cfg_data[VAR_W-1:0];
                CFG_MIN_TRADES: r_min_trades <= i_cfg_data[5:0];
                CFG_INIT_VAR:   r_init_var   <= i_cfg_data[VAR_W-1:0];
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wslot      <= '0;
            r_fill       <= '0;
            r_last_price <= '0;
            r_last_log   <= '0;
            r_var        <= '0;
            r_started    <= 1'b0;
            r_size_thr   <= NW'(10000);
            r_move_thr   <= NW'(10000);
            r_ov         <= 1'b0;
            r_dv         <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                r_wslot      <= (32'(r_wslot) == WINDOW - 1) ? '0 : r_wslot + 1'b1;
                r_last_price <= i_price;
                if (32'(r_fill) < WINDOW) begin
                    r_fill <= r_fill + 1'b1;
                end
            end

            if (r_state == S_LOG && w_log_stat.done) begin
                r_last_log <= w_log;
                if (!r_started) begin
                    // The first trade only loads the starting variance.
                    r_var     <= r_init_var;
                    r_started <= 1'b1;
                end
            end

            if (r_state == S_SAT) begin
                r_var <= (w_ewma_sum[59:56] != '0) ? {VAR_W{1'b1}} : w_ewma_sum[55:16];
            end

            if (r_state == S_PASS) begin
                r_dv <= (r_issue != r_fill);
            end else begin
                r_dv <= 1'b0;
            end

            if (r_state == S_RESOLVE && r_bitm[0]) begin
                r_size_thr <= (NW'(w_pref_v_nx) > NW'(r_size_floor)) ? NW'(w_pref_v_nx)
                                                                     : NW'(r_size_floor);
                // Steps exist only from the second trade on.
                if (32'(r_fill) >= 2) begin
                    r_move_thr <= (NW'(w_pref_s_nx) > NW'(r_move_floor))
                                  ? NW'(w_pref_s_nx) : NW'(r_move_floor);
                end
            end

            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_volume <= i_volume;
            r_change <= w_step;
        end

        case (r_state)
            S_LOG: begin
                r_mag <= (w_ldiff > LOG_CAP) ? LOG_CAP[MAG_W-1:0] : w_ldiff[MAG_W-1:0];
            end
            S_RET: begin
                r_ret <= w_ret_sum[63] ? 31'h7FFF_FFFF : w_ret_sum[62:32];
            end
            S_SQ: begin
                r_sq <= w_sq_sum[61:20];
            end
            S_EWMA: begin
                r_p1 <= r_decay * r_var;
                r_p2 <= w_new_wt * r_sq;
            end
            S_SETUP: begin
                r_addr       <= w_oldest;
                r_issue      <= '0;
                r_first_pass <= 1'b1;
                r_bitm       <= VB'(1) << (VB - 1);
                r_himask     <= '0;
                r_pref_v     <= '0;
                r_pref_s     <= '0;
                r_c_v        <= '0;
                r_c_s        <= '0;
                r_vsum       <= '0;
                r_ssum       <= '0;
                r_k_v        <= CW'((32'(r_fill) * K_VOL_MUL) >> K_SHIFT);
                r_k_s        <= CW'((32'(r_fill - 1'b1) * K_STEP_MUL) >> K_SHIFT);
            end
            S_PASS: begin
                if (r_issue != r_fill) begin
                    r_addr    <= w_addr_inc;
                    r_issue   <= r_issue + 1'b1;
                    r_d_first <= (r_issue == '0);
                end
                if (r_dv) begin
                    // The oldest entry's step belongs to a trade outside the window.
                    if (r_first_pass) begin
                        r_vsum <= r_vsum + SW'(r_rd_vol);
                        if (!r_d_first) begin
                            r_ssum <= r_ssum + SW'(r_rd_step);
                        end
                    end
                    if (w_vmatch) begin
                        r_c_v <= r_c_v + 1'b1;
                    end
                    if (w_smatch && !r_d_first) begin
                        r_c_s <= r_c_s + 1'b1;
                    end
                end
            end
            S_RESOLVE: begin
                r_pref_v     <= w_pref_v_nx;
                r_pref_s     <= w_pref_s_nx;
                r_k_v        <= w_v_hi ? r_k_v - r_c_v : r_k_v;
                r_k_s        <= w_s_hi ? r_k_s - r_c_s : r_k_s;
                r_himask     <= r_himask | r_bitm;
                r_bitm       <= r_bitm >> 1;
                r_c_v        <= '0;
                r_c_s        <= '0;
                r_first_pass <= 1'b0;
                r_addr       <= w_oldest;
                r_issue      <= '0;
            end
            S_CMP: begin
                r_pv1 <= r_volume * r_fill;
                r_pv2 <= r_vsum * r_size_mult;
                r_ps1 <= r_change * (r_fill - 1'b1);
                r_ps2 <= r_ssum * r_dev_mult;
            end
            default: begin
            end
        endcase

        if (w_load_out) begin
            r_pa   <= w_pa;
            r_sa   <= w_sa;
            r_va   <= w_va;
            r_ovar <= r_var;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_price_alert      = r_pa;
    assign o_size_alert       = r_sa;
    assign o_volatility_alert = r_va;
    assign o_variance         = r_ovar;

endmodule

// ===== design/tad_checker.sv =====
`timescale 1ns / 1ps
`include "trade_anomaly_detector_core_macros.svh"

module tad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_price_alert,
    input logic        o_size_alert,
    input logic        o_volatility_alert,
    input logic [39:0] o_variance
);

    // A result that has not been taken stays offered.
    `TAD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    // A stalled result keeps its payload.
    `TAD_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready,
        $stable(o_variance) && $stable(o_price_alert) && $stable(o_size_alert) &&
        $stable(o_volatility_alert), "stalled result changed")

    // An accepted item keeps the block busy in the cycle after acceptance.
    `TAD_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "second item taken at once")

    // A fresh result appears only as the block returns to idle.
    `TAD_ASSERT_NOW(a_result_at_end, $rose(o_out_valid), o_in_ready, "result while busy")

endmodule

bind trade_anomaly_detector_core tad_checker u_tad_checker (.*);
